### hw/rtl/tbs_pkg.sv
// Shared widths, codes and structures of the token bucket packet shaper.
package tbs_pkg;

    localparam int ID_W    = 16;
    localparam int NEED_W  = 10;
    localparam int LEVEL_W = 10;
    localparam int CNT_W   = 16;
    localparam int EVT_W   = 3;

    // Item kinds on the request channel.
    localparam logic FUNC_ARRIVAL = 1'b0;
    localparam logic FUNC_TICK    = 1'b1;

    localparam logic [CNT_W-1:0]   CNT_MAX            = {CNT_W{1'b1}};
    localparam logic [LEVEL_W-1:0] BUCKET_DEPTH_RESET = LEVEL_W'(10);

    // Register map of the configuration port.
    localparam int              APB_AW           = 3;
    localparam logic [APB_AW-1:0] REG_BUCKET_DEPTH = APB_AW'(0);

    typedef enum logic [EVT_W-1:0] {
        EVT_QUEUED        = 3'd0,
        EVT_DROP_OVERSIZE = 3'd1,
        EVT_DROP_FULL     = 3'd2,
        EVT_RELEASED      = 3'd3,
        EVT_TOKEN_ADDED   = 3'd4,
        EVT_TOKEN_DROPPED = 3'd5
    } event_e;

    typedef struct packed {
        event_e             event_res;
        logic [ID_W-1:0]    event_packet;
        logic [LEVEL_W-1:0] bucket_level;
        logic [CNT_W-1:0]   packets_dropped;
        logic [CNT_W-1:0]   tokens_dropped;
        logic               last;
    } result_t;

    typedef struct packed {
        logic push;
        logic pop;
    } queue_ctl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_stat_t;

    typedef struct packed {
        logic push0;
        logic push1;
    } obuf_push_t;

    typedef struct packed {
        logic room2;
    } obuf_stat_t;

endpackage

### hw/rtl/tbs_item_if.sv
// Request channel carrying packet arrivals and token ticks.
interface tbs_item_if
    import tbs_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              func;
    logic [ID_W-1:0]   packet_id;
    logic [NEED_W-1:0] tokens_needed;

    modport source (
        output valid,
        output func,
        output packet_id,
        output tokens_needed,
        input  ready
    );

    modport sink (
        input  valid,
        input  func,
        input  packet_id,
        input  tokens_needed,
        output ready
    );
endinterface

### hw/rtl/tbs_result_if.sv
// Result channel carrying shaper events.
interface tbs_result_if
    import tbs_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [EVT_W-1:0]   event_res;
    logic [ID_W-1:0]    event_packet;
    logic [LEVEL_W-1:0] bucket_level;
    logic [CNT_W-1:0]   packets_dropped;
    logic [CNT_W-1:0]   tokens_dropped;
    logic               last;

    modport source (
        output valid,
        output event_res,
        output event_packet,
        output bucket_level,
        output packets_dropped,
        output tokens_dropped,
        output last,
        input  ready
    );

    modport sink (
        input  valid,
        input  event_res,
        input  event_packet,
        input  bucket_level,
        input  packets_dropped,
        input  tokens_dropped,
        input  last,
        output ready
    );
endinterface

### hw/rtl/tbs_queue.sv
// Packet FIFO in a memory with a look-ahead read of the head entry.
module tbs_queue
    import tbs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  queue_ctl_t        ctl,
    input  logic [ID_W-1:0]   push_id,
    input  logic [NEED_W-1:0] push_need,
    output queue_stat_t       stat,
    output logic [ID_W-1:0]   head_id,
    output logic [NEED_W-1:0] head_need
);

    localparam int AW      = $clog2(QUEUE_DEPTH);
    localparam int CW      = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = ID_W + NEED_W;
    localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
    logic [AW-1:0]      head_reg, head_next;
    logic [AW-1:0]      tail_reg, tail_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [ENTRY_W-1:0] byp_data_reg;
    logic               byp_hit_reg;
    logic [ENTRY_W-1:0] wr_data;
    logic [ENTRY_W-1:0] head_entry;

    assign wr_data = {push_id, push_need};

    // Pointer and fill count updates; pointers wrap at the last entry.
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctl.pop)
        begin
            head_next = (head_reg == LAST_IDX) ? '0 : head_reg + AW'(1);
        end
        if (ctl.push)
        begin
            tail_next = (tail_reg == LAST_IDX) ? '0 : tail_reg + AW'(1);
        end
        if (ctl.push && !ctl.pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctl.pop && !ctl.push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            byp_hit_reg <= 1'b0;
        end
        else
        begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            byp_hit_reg <= ctl.push && (tail_reg == head_next);
        end
    end

    // Memory: write at the tail, read the entry that is head in the next cycle.
    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[tail_reg] <= wr_data;
        end
        rd_data_reg  <= mem[head_next];
        byp_data_reg <= wr_data;
    end

    // A write to the address being read this cycle is forwarded.
    assign head_entry = byp_hit_reg ? byp_data_reg : rd_data_reg;
    assign head_id    = head_entry[ENTRY_W-1:NEED_W];
    assign head_need  = head_entry[NEED_W-1:0];
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == FULL_CNT);

endmodule

### hw/rtl/tbs_out_buf.sv
// Four-entry result buffer that takes up to two results per cycle.
module tbs_out_buf
    import tbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  obuf_push_t push,
    input  result_t    data0,
    input  result_t    data1,
    output obuf_stat_t stat,
    output logic       out_valid,
    input  logic       out_ready,
    output result_t    out_data
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] ROOM2_MAX = CW'(DEPTH - 2);

    result_t       buf_reg [DEPTH];
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          pop;
    logic [CW-1:0] n_push;

    assign pop    = out_valid && out_ready;
    assign n_push = CW'(push.push0) + CW'(push.push1);

    always_comb
    begin
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg + PW'(n_push);
        count_next  = count_reg + n_push - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage; the second result goes in the slot after the first.
    always_ff @(posedge clk)
    begin
        if (push.push0)
        begin
            buf_reg[wr_ptr_reg] <= data0;
        end
        if (push.push1)
        begin
            buf_reg[wr_ptr_reg + PW'(1)] <= data1;
        end
    end

    assign out_valid  = (count_reg != '0);
    assign out_data   = buf_reg[rd_ptr_reg];
    assign stat.room2 = (count_reg <= ROOM2_MAX);

endmodule

### hw/rtl/tbs_core.sv
// Request register, bucket state and the decision logic for one request.
module tbs_core
    import tbs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [LEVEL_W-1:0] bucket_depth,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               in_func,
    input  logic [ID_W-1:0]    in_packet_id,
    input  logic [NEED_W-1:0]  in_tokens_needed,
    output queue_ctl_t         q_ctl,
    output logic [ID_W-1:0]    q_push_id,
    output logic [NEED_W-1:0]  q_push_need,
    input  queue_stat_t        q_stat,
    input  logic [ID_W-1:0]    q_head_id,
    input  logic [NEED_W-1:0]  q_head_need,
    output obuf_push_t         ob_push,
    output result_t            ob_data0,
    output result_t            ob_data1,
    input  obuf_stat_t         ob_stat
);

    logic               item_valid_reg;
    logic               item_func_reg;
    logic [ID_W-1:0]    item_id_reg;
    logic [NEED_W-1:0]  item_need_reg;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [CNT_W-1:0]   pkt_drop_reg, pkt_drop_next;
    logic [CNT_W-1:0]   tok_drop_reg, tok_drop_next;
    logic               advance;
    logic               oversize;
    logic               release_head;
    logic [LEVEL_W-1:0] level_after_rel;
    logic               token_full;
    event_e             arrival_evt;

    // The held request is processed once the result buffer has room for two.
    assign advance  = item_valid_reg && ob_stat.room2;
    assign in_ready = !item_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_func_reg <= in_func;
            item_id_reg   <= in_packet_id;
            item_need_reg <= in_tokens_needed;
        end
    end

    // Arrival: oversize check against the depth, then the queue space check.
    assign oversize = (item_need_reg > bucket_depth);

    always_comb
    begin
        if (oversize)
        begin
            arrival_evt = EVT_DROP_OVERSIZE;
        end
        else if (q_stat.full)
        begin
            arrival_evt = EVT_DROP_FULL;
        end
        else
        begin
            arrival_evt = EVT_QUEUED;
        end
    end

    // Tick: release the head when it fits, then add or drop one token.
    assign release_head    = !q_stat.empty && (q_head_need <= level_reg);
    assign level_after_rel = release_head ? level_reg - q_head_need : level_reg;
    assign token_full      = (level_after_rel >= bucket_depth);

    always_comb
    begin
        level_next    = level_reg;
        pkt_drop_next = pkt_drop_reg;
        tok_drop_next = tok_drop_reg;
        q_ctl         = '0;
        ob_push       = '0;
        ob_data0      = '0;
        ob_data1      = '0;
        q_push_id     = item_id_reg;
        q_push_need   = item_need_reg;

        if (advance && item_func_reg == FUNC_ARRIVAL)
        begin
            if (arrival_evt != EVT_QUEUED)
            begin
                pkt_drop_next = (pkt_drop_reg == CNT_MAX) ? pkt_drop_reg
                                                          : pkt_drop_reg + CNT_W'(1);
            end
            q_ctl.push                = (arrival_evt == EVT_QUEUED);
            ob_push.push0             = 1'b1;
            ob_data0.event_res        = arrival_evt;
            ob_data0.event_packet     = item_id_reg;
            ob_data0.bucket_level     = level_reg;
            ob_data0.packets_dropped  = pkt_drop_next;
            ob_data0.tokens_dropped   = tok_drop_reg;
            ob_data0.last             = 1'b1;
        end
        else if (advance)
        begin
            if (token_full)
            begin
                level_next    = level_after_rel;
                tok_drop_next = (tok_drop_reg == CNT_MAX) ? tok_drop_reg
                                                          : tok_drop_reg + CNT_W'(1);
            end
            else
            begin
                level_next = level_after_rel + LEVEL_W'(1);
            end
            q_ctl.pop = release_head;

            // Token result, first slot when nothing is released.
            ob_data1.event_res       = token_full ? EVT_TOKEN_DROPPED : EVT_TOKEN_ADDED;
            ob_data1.event_packet    = '0;
            ob_data1.bucket_level    = level_next;
            ob_data1.packets_dropped = pkt_drop_reg;
            ob_data1.tokens_dropped  = tok_drop_next;
            ob_data1.last            = 1'b1;

            if (release_head)
            begin
                ob_push.push0            = 1'b1;
                ob_push.push1            = 1'b1;
                ob_data0.event_res       = EVT_RELEASED;
                ob_data0.event_packet    = q_head_id;
                ob_data0.bucket_level    = level_after_rel;
                ob_data0.packets_dropped = pkt_drop_reg;
                ob_data0.tokens_dropped  = tok_drop_reg;
                ob_data0.last            = 1'b0;
            end
            else
            begin
                ob_push.push0 = 1'b1;
                ob_data0      = ob_data1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg    <= '0;
            pkt_drop_reg <= '0;
            tok_drop_reg <= '0;
        end
        else
        begin
            level_reg    <= level_next;
            pkt_drop_reg <= pkt_drop_next;
            tok_drop_reg <= tok_drop_next;
        end
    end

endmodule

### hw/rtl/token_bucket_packet_shaper.sv
// Token bucket packet shaper top level with its configuration registers.
//
// Requests enter on the item channel: func 0 is a packet arrival with a
// packet_id and tokens_needed, func 1 is one token tick. Events leave on
// the result channel, one per handshake; an arrival gives one event, a
// tick gives a release event (last low) when the queue head fits the
// bucket, then always one token event (last high).
// A request is taken into an input register, decided once the result
// buffer has room for two events and written into that four-entry
// buffer, whose output drives the result channel. Arrivals flow at one
// per cycle while the result receiver keeps up; a tick that releases a
// packet gives two events, so the result channel's one event per cycle sets the sustained rate.
// The bucket depth register (reset 10) sits at address 0 of the APB port.
// Reset empties the packet queue, the result buffer, the bucket and both
// drop counters. When the result receiver stalls, the buffer fills and
// the item channel drops ready until room for two events is free.
module token_bucket_packet_shaper
    import tbs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    tbs_item_if.sink          item,
    tbs_result_if.source      result
);

    logic [LEVEL_W-1:0] bucket_depth_reg;
    queue_ctl_t         q_ctl;
    queue_stat_t        q_stat;
    logic [ID_W-1:0]    q_push_id;
    logic [NEED_W-1:0]  q_push_need;
    logic [ID_W-1:0]    q_head_id;
    logic [NEED_W-1:0]  q_head_need;
    obuf_push_t         ob_push;
    obuf_stat_t         ob_stat;
    result_t            ob_data0;
    result_t            ob_data1;
    result_t            out_data;
    logic               out_valid;

    // Configuration register write and read-back.
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_depth_reg <= BUCKET_DEPTH_RESET;
        end
        else if (psel && penable && pwrite && paddr == REG_BUCKET_DEPTH)
        begin
            bucket_depth_reg <= pwdata[LEVEL_W-1:0];
        end
    end

    assign prdata = (paddr == REG_BUCKET_DEPTH) ? {{(32 - LEVEL_W){1'b0}}, bucket_depth_reg}
                                                : '0;

    tbs_core u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .bucket_depth     (bucket_depth_reg),
        .in_valid         (item.valid),
        .in_ready         (item.ready),
        .in_func          (item.func),
        .in_packet_id     (item.packet_id),
        .in_tokens_needed (item.tokens_needed),
        .q_ctl            (q_ctl),
        .q_push_id        (q_push_id),
        .q_push_need      (q_push_need),
        .q_stat           (q_stat),
        .q_head_id        (q_head_id),
        .q_head_need      (q_head_need),
        .ob_push          (ob_push),
        .ob_data0         (ob_data0),
        .ob_data1         (ob_data1),
        .ob_stat          (ob_stat)
    );

    tbs_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (q_ctl),
        .push_id   (q_push_id),
        .push_need (q_push_need),
        .stat      (q_stat),
        .head_id   (q_head_id),
        .head_need (q_head_need)
    );

    tbs_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (ob_push),
        .data0     (ob_data0),
        .data1     (ob_data1),
        .stat      (ob_stat),
        .out_valid (out_valid),
        .out_ready (result.ready),
        .out_data  (out_data)
    );

    // Result channel payload.
    assign result.valid           = out_valid;
    assign result.event_res       = out_data.event_res;
    assign result.event_packet    = out_data.event_packet;
    assign result.bucket_level    = out_data.bucket_level;
    assign result.packets_dropped = out_data.packets_dropped;
    assign result.tokens_dropped  = out_data.tokens_dropped;
    assign result.last            = out_data.last;

endmodule

### tb/sv/shaper_check_pkg.sv
// Scoreboard for the token bucket shaper: event prediction and result checking.
package shaper_check_pkg;
    import tbs_pkg::*;

    localparam int SHAPER_QUEUE_DEPTH = 64;

    class shaper_scoreboard;
        logic [LEVEL_W-1:0] depth;
        logic [LEVEL_W-1:0] level;
        logic [ID_W-1:0]    held_ids[$];
        logic [NEED_W-1:0]  held_needs[$];
        logic [CNT_W-1:0]   packet_drops;
        logic [CNT_W-1:0]   token_drops;
        result_t            due_events[$];
        int                 mismatches;
        int                 requests;
        int                 events_checked;
        int                 event_tally[8];

        function new();
            depth          = BUCKET_DEPTH_RESET;
            level          = '0;
            packet_drops   = '0;
            token_drops    = '0;
            mismatches     = 0;
            requests       = 0;
            events_checked = 0;
            foreach (event_tally[i])
                event_tally[i] = 0;
        endfunction

        function void set_depth(logic [LEVEL_W-1:0] value);
            depth = value;
        endfunction

        function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] count);
            return (count == CNT_MAX) ? CNT_MAX : count + 1'b1;
        endfunction

        // Record one event with the state as it stands after that event.
        function void add_event(event_e kind, logic [ID_W-1:0] id, logic last);
            result_t ev;
            ev.event_res       = kind;
            ev.event_packet    = id;
            ev.bucket_level    = level;
            ev.packets_dropped = packet_drops;
            ev.tokens_dropped  = token_drops;
            ev.last            = last;
            due_events.push_back(ev);
        endfunction

        // Advance the shaper state by one accepted request.
        function void note_request(logic func, logic [ID_W-1:0] id, logic [NEED_W-1:0] need);
            logic [ID_W-1:0] head_id;
            requests++;
            if (func == FUNC_ARRIVAL)
            begin
                if (need > depth)
                begin
                    packet_drops = bump(packet_drops);
                    add_event(EVT_DROP_OVERSIZE, id, 1'b1);
                end
                else if (held_ids.size() >= SHAPER_QUEUE_DEPTH)
                begin
                    packet_drops = bump(packet_drops);
                    add_event(EVT_DROP_FULL, id, 1'b1);
                end
                else
                begin
                    held_ids.push_back(id);
                    held_needs.push_back(need);
                    add_event(EVT_QUEUED, id, 1'b1);
                end
            end
            else
            begin
                // The head goes out first when the bucket covers its need.
                if (held_ids.size() > 0 && held_needs[0] <= level)
                begin
                    level   = level - held_needs.pop_front();
                    head_id = held_ids.pop_front();
                    add_event(EVT_RELEASED, head_id, 1'b0);
                end
                // A full bucket, or one left above a lowered depth, loses the token.
                if (level >= depth)
                begin
                    token_drops = bump(token_drops);
                    add_event(EVT_TOKEN_DROPPED, '0, 1'b1);
                end
                else
                begin
                    level = level + 1'b1;
                    add_event(EVT_TOKEN_ADDED, '0, 1'b1);
                end
            end
        endfunction

        function void check_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_readback(logic [31:0] seen);
            check_field("bucket_depth", 32'(depth), seen);
        endfunction

        // Compare one delivered event with the oldest one still due.
        function void check_event(result_t got);
            result_t want;
            if (due_events.size() == 0)
            begin
                $error("event_res %0d for packet %0d arrived with nothing due",
                       got.event_res, got.event_packet);
                mismatches++;
                return;
            end
            want = due_events.pop_front();
            events_checked++;
            event_tally[want.event_res]++;
            check_field("event_res", 32'(want.event_res), 32'(got.event_res));
            check_field("event_packet", 32'(want.event_packet), 32'(got.event_packet));
            check_field("bucket_level", 32'(want.bucket_level), 32'(got.bucket_level));
            check_field("packets_dropped", 32'(want.packets_dropped),
                        32'(got.packets_dropped));
            check_field("tokens_dropped", 32'(want.tokens_dropped), 32'(got.tokens_dropped));
            check_field("last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

endpackage

### tb/sv/tb_top.sv
// Top-level testbench of the token bucket packet shaper.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tbs_pkg::*;
    import shaper_check_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 3_000_000;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          DRAIN_CYCLES  = 32;
    localparam int          LONG_HOLD     = 400;
    localparam logic [APB_AW-1:0] UNMAPPED_REG_ADDR = APB_AW'(4);

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    int unsigned       cycles = 0;
    bit                burst  = 1'b0;
    shaper_scoreboard  sb     = new();

    tbs_item_if   item_ch ();
    tbs_result_if event_ch ();

    token_bucket_packet_shaper #(
        .QUEUE_DEPTH(SHAPER_QUEUE_DEPTH)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .item    (item_ch),
        .result  (event_ch)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("** token_bucket_packet_shaper: FAILED **");
            $finish;
        end
    end

    // Every delivered event is checked against the prediction.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && event_ch.valid === 1'b1 && event_ch.ready === 1'b1)
            sb.check_event({event_ch.event_res, event_ch.event_packet, event_ch.bucket_level,
                            event_ch.packets_dropped, event_ch.tokens_dropped,
                            event_ch.last});
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(1, 2);
        if (roll < 94)
            return $urandom_range(3, 8);
        return $urandom_range(16, 60);
    endfunction

    // Result receiver: random stalls, calm stretches and two long hold-offs.
    initial
    begin : result_receiver
        int stall_left;
        int hold_left;
        int holds_done;
        int span;
        bit calm;
        stall_left     = 0;
        hold_left      = 0;
        holds_done     = 0;
        span           = 0;
        calm           = 1'b0;
        event_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && holds_done < 2 && sb.requests >= 300 + holds_done * 700)
            begin
                hold_left = LONG_HOLD;
                holds_done++;
            end
            if (span == 0)
            begin
                calm = ($urandom_range(0, 3) == 0);
                span = $urandom_range(100, 400);
            end
            span--;
            if (hold_left > 0)
            begin
                hold_left--;
                event_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                event_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 99) < 15)
            begin
                stall_left = pick_gap() - 1;
                event_ch.ready <= 1'b0;
            end
            else
                event_ch.ready <= 1'b1;
        end
    end

    // Keep the request channel idle, with noise on the payload.
    task automatic hold_back(int n);
        repeat (n)
        begin
            @(negedge clk);
            item_ch.valid         <= 1'b0;
            item_ch.func          <= 1'($urandom);
            item_ch.packet_id     <= ID_W'($urandom);
            item_ch.tokens_needed <= NEED_W'($urandom);
        end
    endtask

    // Offer one request, possibly after a gap, and note it once it is taken.
    task automatic send_request(logic func, logic [ID_W-1:0] id, logic [NEED_W-1:0] need);
        if (!burst && $urandom_range(0, 99) < 30)
            hold_back(pick_gap());
        @(negedge clk);
        item_ch.valid         <= 1'b1;
        item_ch.func          <= func;
        item_ch.packet_id     <= id;
        item_ch.tokens_needed <= need;
        do
            @(posedge clk);
        while (item_ch.ready !== 1'b1);
        sb.note_request(func, id, need);
    endtask

    task automatic apb_write(logic [APB_AW-1:0] addr, logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        if (addr == REG_BUCKET_DEPTH)
            sb.set_depth(data[LEVEL_W-1:0]);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read(logic [APB_AW-1:0] addr, output logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        data = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Wait until every predicted event has been delivered.
    task automatic wait_idle();
        hold_back(1);
        while (sb.due_events.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_depth(logic [LEVEL_W-1:0] value);
        logic [31:0] readback;
        wait_idle();
        apb_write(REG_BUCKET_DEPTH, 32'(value));
        apb_read(REG_BUCKET_DEPTH, readback);
        sb.check_readback(readback);
    endtask

    // Tick until every queued packet has gone out.
    task automatic drain_queue();
        while (sb.held_ids.size() > 0)
            send_request(FUNC_TICK, ID_W'($urandom), NEED_W'($urandom));
    endtask

    // Empty the queue, then spend the bucket on one packet so the next phase starts low.
    task automatic empty_shaper();
        drain_queue();
        if (sb.level > 0 && sb.level <= sb.depth)
        begin
            send_request(FUNC_ARRIVAL, ID_W'($urandom), sb.level);
            send_request(FUNC_TICK, ID_W'($urandom), NEED_W'($urandom));
        end
    endtask

    // Random mix of ticks and arrivals; most needs are small enough for the ticks
    // to keep up with, and some exceed the depth.
    task automatic run_random(int count, int tick_pct);
        int               k;
        int               roll;
        logic [NEED_W-1:0] need;
        for (k = 0; k < count; k++)
        begin
            if (k % 80 == 0)
                burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < tick_pct)
                send_request(FUNC_TICK, ID_W'($urandom), NEED_W'($urandom));
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 15)
                    need = '0;
                else if (roll < 70)
                    need = NEED_W'($urandom_range(0, (sb.depth < 3) ? sb.depth : 3));
                else if (roll < 90)
                    need = NEED_W'($urandom_range(0, (sb.depth < 15) ? sb.depth : 15));
                else if (sb.depth < 10'h3FF)
                    need = NEED_W'($urandom_range(sb.depth + 1, 1023));
                else
                    need = NEED_W'($urandom_range(0, 15));
                send_request(FUNC_ARRIVAL, ID_W'($urandom), need);
            end
        end
        burst = 1'b0;
    endtask

    initial
    begin : stimulus
        logic [31:0] readback;
        int          k;
        item_ch.valid         = 1'b0;
        item_ch.func          = FUNC_ARRIVAL;
        item_ch.packet_id     = '0;
        item_ch.tokens_needed = '0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        rst_n                 = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Depth register after reset.
        apb_read(REG_BUCKET_DEPTH, readback);
        sb.check_readback(readback);

        // Reset depth: tick on an empty queue, field extremes, oversize and exact fit.
        send_request(FUNC_TICK, 16'hFFFF, 10'h3FF);
        send_request(FUNC_ARRIVAL, 16'h0000, 10'd0);
        send_request(FUNC_ARRIVAL, 16'hFFFF, 10'h3FF);
        send_request(FUNC_ARRIVAL, 16'h1234, 10'd11);
        send_request(FUNC_ARRIVAL, 16'hA5A5, 10'd10);
        repeat (14) send_request(FUNC_TICK, 16'h0000, 10'd0);

        // Depth zero below the current level: zero-need packets go out one per tick.
        program_depth('0);
        send_request(FUNC_ARRIVAL, 16'h0007, 10'd0);
        send_request(FUNC_ARRIVAL, 16'h0008, 10'd0);
        send_request(FUNC_ARRIVAL, 16'h0009, 10'd1);
        repeat (3) send_request(FUNC_TICK, 16'h5A5A, 10'h155);

        // A write to an unmapped register must leave the depth alone.
        wait_idle();
        apb_write(UNMAPPED_REG_ADDR, 32'h0000_03FF);
        apb_read(REG_BUCKET_DEPTH, readback);
        sb.check_readback(readback);

        // Random phases across a range of depths.
        empty_shaper();
        program_depth(10'h3FF);
        run_random(250, 70);
        empty_shaper();
        program_depth(10'd3);
        run_random(180, 35);
        empty_shaper();
        program_depth(LEVEL_W'($urandom_range(4, 1022)));
        run_random(180, 50);
        empty_shaper();
        program_depth(10'd40);
        run_random(180, 20);
        empty_shaper();
        program_depth(10'd1);
        run_random(130, 50);

        // Build the level up, then lower the depth beneath it.
        empty_shaper();
        program_depth(10'h3FF);
        run_random(180, 85);
        drain_queue();
        program_depth(10'd6);
        run_random(100, 60);

        // Depth zero: every arrival is oversize and every tick loses its token.
        empty_shaper();
        program_depth('0);
        burst = 1'b1;
        for (k = 0; k < 20; k++)
        begin
            send_request(FUNC_ARRIVAL, ID_W'($urandom), NEED_W'($urandom_range(1, 1023)));
            send_request(FUNC_TICK, ID_W'($urandom), NEED_W'($urandom));
        end
        burst = 1'b0;

        hold_back(1);
        while (sb.due_events.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run summary: %0d requests, %0d events checked in %0d cycles.",
                 sb.requests, sb.events_checked, cycles);
        $display("Events: queued %0d, oversize %0d, queue full %0d, released %0d, %s %0d, %s %0d.",
                 sb.event_tally[EVT_QUEUED], sb.event_tally[EVT_DROP_OVERSIZE],
                 sb.event_tally[EVT_DROP_FULL], sb.event_tally[EVT_RELEASED],
                 "token added", sb.event_tally[EVT_TOKEN_ADDED],
                 "token dropped", sb.event_tally[EVT_TOKEN_DROPPED]);
        if (sb.mismatches == 0)
            $display("** token_bucket_packet_shaper: PASSED **");
        else
            $display("** token_bucket_packet_shaper: FAILED **");
        $finish;
    end

endmodule
